### rtl/core/hash_directory_table_engine_top_assert.svh
// Assertion macros for the hash directory engine.
// Both macros expect clk_i and rst_ni in the including scope.
`ifndef HASH_DIRECTORY_TABLE_ENGINE_TOP_ASSERT_SVH
`define HASH_DIRECTORY_TABLE_ENGINE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HDTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define HDTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HDTE_ASSERT_IMP(lbl, ante, cons, msg)
`define HDTE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/core/hdt_pkg.sv
package hdt_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STRIDE_W = 11;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned ERR_W    = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 3'd0,
    CMD_DOUBLE = 3'd1,
    CMD_FILL   = 3'd2,
    CMD_MERGE  = 3'd3,
    CMD_HALVE  = 3'd4,
    CMD_APPEND = 3'd5
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_LOOKUP,
    ST_DOUBLE,
    ST_FILL_DN,
    ST_FILL_UP,
    ST_MOD,
    ST_MERGE_ADDR,
    ST_MERGE_CMP,
    ST_HALVE,
    ST_DONE
  } state_e;

  // one result word
  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    logic              success;
    logic [SIZE_W-1:0] table_size;
    err_e              error;
  } res_t;

endpackage

### rtl/core/hdt_dir_mem.sv
module hdt_dir_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DW-1:0]            wdata_i,
  input  logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic [DW-1:0]            ra_data_o,
  output logic [DW-1:0]            rb_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DW-1:0] dir_mem [DEPTH];
  logic [DW-1:0] ra_q, rb_q;
  logic          e0_wr_q;      // entry 0 written since reset
  logic          ra_dflt_q, rb_dflt_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dir_mem[waddr_i] <= wdata_i;
    end
    ra_q <= dir_mem[ra_addr_i];
    rb_q <= dir_mem[rb_addr_i];
  end

  // entry 0 reads as 1 until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_wr_q   <= 1'b0;
      ra_dflt_q <= 1'b0;
      rb_dflt_q <= 1'b0;
    end else begin
      if (we_i && (waddr_i == AW'(0))) begin
        e0_wr_q <= 1'b1;
      end
      ra_dflt_q <= (ra_addr_i == AW'(0)) && !e0_wr_q;
      rb_dflt_q <= (rb_addr_i == AW'(0)) && !e0_wr_q;
    end
  end

  assign ra_data_o = ra_dflt_q ? DW'(1) : ra_q;
  assign rb_data_o = rb_dflt_q ? DW'(1) : rb_q;

endmodule

### rtl/core/hdt_rem.sv
module hdt_rem #(
  parameter int unsigned DIV_W = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [hdt_pkg::STRIDE_W-1:0] dividend_i,
  input  logic [DIV_W-1:0]             divisor_i,
  output logic [DIV_W-1:0]             rem_o,
  output logic                         done_o
);

  localparam int unsigned NW    = hdt_pkg::STRIDE_W;
  localparam int unsigned CNT_W = $clog2(NW);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [NW-1:0]    dvd_q, dvd_d;
  logic [DIV_W:0]   trial, diff;

  // restoring remainder, one dividend bit a cycle
  always_comb begin
    trial  = {rem_q, dvd_q[NW-1]};
    diff   = trial - {1'b0, divisor_i};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, divisor_i}) ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_d = {dvd_q[NW-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### rtl/core/hdt_seq.sv
module hdt_seq #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned BLOCK_BITS  = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [hdt_pkg::CMD_W-1:0]            cmd_i,
  input  logic [hdt_pkg::POS_W-1:0]            position_i,
  input  logic [hdt_pkg::VAL_W-1:0]            block_value_i,
  input  logic [hdt_pkg::STRIDE_W-1:0]         stride_i,
  input  logic                                 res_take_i,
  output logic                                 idle_o,
  output logic                                 res_valid_o,
  output hdt_pkg::res_t                        res_o,
  output logic                                 we_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       waddr_o,
  output logic [BLOCK_BITS-1:0]                wdata_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       ra_addr_o,
  output logic [$clog2(MAX_ENTRIES)-1:0]       rb_addr_o,
  input  logic [BLOCK_BITS-1:0]                ra_data_i,
  input  logic [BLOCK_BITS-1:0]                rb_data_i,
  output logic                                 rem_start_o,
  output logic [hdt_pkg::STRIDE_W-1:0]         rem_dividend_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]     rem_divisor_o,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]     rem_i,
  input  logic                                 rem_done_i
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SW = ((CW > hdt_pkg::STRIDE_W) ? CW : hdt_pkg::STRIDE_W) + 1;
  localparam int unsigned BW = BLOCK_BITS;

  hdt_pkg::state_e state_q, state_d;
  hdt_pkg::err_e   err_q, err_d;

  logic [hdt_pkg::CMD_W-1:0]    cmd_q;
  logic [hdt_pkg::POS_W-1:0]    pos_q;
  logic [BW-1:0]                val_q;
  logic [hdt_pkg::STRIDE_W-1:0] stride_q;
  logic [CW-1:0]                count_q, count_d;
  logic                         loaded_q, loaded_d;
  logic [CW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                pidx_q, pidx_d;
  logic                         pend_q, pend_d;
  logic [SW-1:0]                cur_q, cur_d;
  logic [CW-1:0]                s_q, s_d;
  logic [hdt_pkg::VAL_W-1:0]    rdv_q, rdv_d;
  logic                         succ_q, succ_d;

  logic [63:0]   val64, rd64;
  logic [31:0]   cnt32;
  logic [SW-1:0] pos_x, cnt_x, str_x, r_sum, l_sum, r_idx, l_idx;
  logic [CW-1:0] half, dbl_addr, hb_addr;

  assign val64    = 64'(block_value_i);
  assign rd64     = 64'(ra_data_i);
  assign cnt32    = 32'(count_q);
  assign pos_x    = SW'(pos_q);
  assign cnt_x    = SW'(count_q);
  assign str_x    = SW'(stride_q);
  assign half     = count_q >> 1;
  assign dbl_addr = count_q + pidx_q;
  assign hb_addr  = idx_q + half;
  // buddy positions, both wrapped into [0, count)
  assign r_sum    = pos_x + SW'(s_q);
  assign l_sum    = pos_x + cnt_x - SW'(s_q);
  assign r_idx    = (r_sum >= cnt_x) ? r_sum - cnt_x : r_sum;
  assign l_idx    = (l_sum >= cnt_x) ? l_sum - cnt_x : l_sum;

  always_comb begin
    state_d     = state_q;
    err_d       = err_q;
    count_d     = count_q;
    loaded_d    = loaded_q;
    idx_d       = idx_q;
    pidx_d      = pidx_q;
    pend_d      = 1'b0;
    cur_d       = cur_q;
    s_d         = s_q;
    rdv_d       = rdv_q;
    succ_d      = succ_q;
    we_o        = 1'b0;
    waddr_o     = '0;
    wdata_o     = val_q;
    ra_addr_o   = '0;
    rb_addr_o   = '0;
    rem_start_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      hdt_pkg::ST_IDLE: begin
        if (start_i) begin
          rdv_d   = '0;
          succ_d  = 1'b0;
          err_d   = hdt_pkg::ERR_NONE;
          state_d = hdt_pkg::ST_START;
        end
      end

      hdt_pkg::ST_START: begin
        state_d = hdt_pkg::ST_DONE;
        case (hdt_pkg::cmd_e'(cmd_q))
          hdt_pkg::CMD_LOOKUP: begin
            if (pos_x >= cnt_x) begin
              err_d = hdt_pkg::ERR_RANGE;
            end else begin
              ra_addr_o = pos_x[AW-1:0];
              state_d   = hdt_pkg::ST_LOOKUP;
            end
          end
          hdt_pkg::CMD_DOUBLE: begin
            if ((cnt_x << 1) > SW'(MAX_ENTRIES)) begin
              err_d = hdt_pkg::ERR_FULL;
            end else begin
              idx_d   = '0;
              state_d = hdt_pkg::ST_DOUBLE;
            end
          end
          hdt_pkg::CMD_FILL: begin
            if (pos_x >= cnt_x) begin
              err_d = hdt_pkg::ERR_RANGE;
            end else begin
              cur_d   = pos_x;
              state_d = hdt_pkg::ST_FILL_DN;
            end
          end
          hdt_pkg::CMD_MERGE: begin
            if (pos_x >= cnt_x) begin
              err_d = hdt_pkg::ERR_RANGE;
            end else if (count_q == CW'(1)) begin
              succ_d = 1'b1;
            end else begin
              rem_start_o = 1'b1;
              state_d     = hdt_pkg::ST_MOD;
            end
          end
          hdt_pkg::CMD_HALVE: begin
            if (half != '0) begin
              idx_d   = '0;
              state_d = hdt_pkg::ST_HALVE;
            end
          end
          hdt_pkg::CMD_APPEND: begin
            if (!loaded_q) begin
              we_o     = 1'b1;
              count_d  = CW'(1);
              loaded_d = 1'b1;
              succ_d   = 1'b1;
            end else if (count_q >= CW'(MAX_ENTRIES)) begin
              err_d = hdt_pkg::ERR_FULL;
            end else begin
              we_o    = 1'b1;
              waddr_o = count_q[AW-1:0];
              count_d = count_q + CW'(1);
              succ_d  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      hdt_pkg::ST_LOOKUP: begin
        rdv_d   = rd64[hdt_pkg::VAL_W-1:0];
        succ_d  = 1'b1;
        state_d = hdt_pkg::ST_DONE;
      end

      // read entry i, write it to count+i in the next cycle
      hdt_pkg::ST_DOUBLE: begin
        if (idx_q < count_q) begin
          ra_addr_o = idx_q[AW-1:0];
          pend_d    = 1'b1;
          pidx_d    = idx_q;
          idx_d     = idx_q + CW'(1);
        end
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = dbl_addr[AW-1:0];
          wdata_o = ra_data_i;
        end else if (idx_q >= count_q) begin
          count_d = count_q << 1;
          succ_d  = 1'b1;
          state_d = hdt_pkg::ST_DONE;
        end
      end

      // walk down from position, then up from position + stride
      hdt_pkg::ST_FILL_DN: begin
        we_o    = 1'b1;
        waddr_o = cur_q[AW-1:0];
        if (stride_q == '0) begin
          succ_d  = 1'b1;
          state_d = hdt_pkg::ST_DONE;
        end else if (cur_q >= str_x) begin
          cur_d = cur_q - str_x;
        end else begin
          cur_d   = pos_x + str_x;
          state_d = hdt_pkg::ST_FILL_UP;
        end
      end

      hdt_pkg::ST_FILL_UP: begin
        if (cur_q < cnt_x) begin
          we_o    = 1'b1;
          waddr_o = cur_q[AW-1:0];
          cur_d   = cur_q + str_x;
        end else begin
          succ_d  = 1'b1;
          state_d = hdt_pkg::ST_DONE;
        end
      end

      hdt_pkg::ST_MOD: begin
        if (rem_done_i) begin
          s_d     = rem_i;
          state_d = hdt_pkg::ST_MERGE_ADDR;
        end
      end

      hdt_pkg::ST_MERGE_ADDR: begin
        ra_addr_o = l_idx[AW-1:0];
        rb_addr_o = r_idx[AW-1:0];
        state_d   = hdt_pkg::ST_MERGE_CMP;
      end

      hdt_pkg::ST_MERGE_CMP: begin
        if (ra_data_i == rb_data_i) begin
          we_o    = 1'b1;
          waddr_o = pos_x[AW-1:0];
          wdata_o = ra_data_i;
          succ_d  = 1'b1;
        end
        state_d = hdt_pkg::ST_DONE;
      end

      // compare entry i with i + half, one pair a cycle
      hdt_pkg::ST_HALVE: begin
        if (idx_q < half) begin
          ra_addr_o = idx_q[AW-1:0];
          rb_addr_o = hb_addr[AW-1:0];
          pend_d    = 1'b1;
          idx_d     = idx_q + CW'(1);
        end
        if (pend_q && (ra_data_i != rb_data_i)) begin
          state_d = hdt_pkg::ST_DONE;
        end else if (!pend_q && (idx_q >= half)) begin
          count_d = half;
          succ_d  = 1'b1;
          state_d = hdt_pkg::ST_DONE;
        end
      end

      hdt_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = hdt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = hdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hdt_pkg::ST_IDLE;
      count_q  <= CW'(1);
      loaded_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      loaded_q <= loaded_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q    <= cmd_i;
      pos_q    <= position_i;
      val_q    <= val64[BW-1:0];
      stride_q <= stride_i;
    end
    err_q  <= err_d;
    idx_q  <= idx_d;
    pidx_q <= pidx_d;
    cur_q  <= cur_d;
    s_q    <= s_d;
    rdv_q  <= rdv_d;
    succ_q <= succ_d;
  end

  assign idle_o         = (state_q == hdt_pkg::ST_IDLE);
  assign rem_dividend_o = stride_q;
  assign rem_divisor_o  = count_q;

  assign res_o.read_value = rdv_q;
  assign res_o.success    = succ_q;
  assign res_o.table_size = cnt32[hdt_pkg::SIZE_W-1:0];
  assign res_o.error      = err_q;

endmodule

### rtl/core/hash_directory_table_engine_top.sv
// Extendible-hash directory engine: a table of block numbers held in one
// synchronous RAM (one write port, two registered read ports), plus an
// entry count, reset to a single entry holding 1. One command word in gives
// one result word out, N being the current size. Double reads each entry and
// writes a copy of it to entry N+i through the single write port; stride
// fill writes each touched entry once, about N/stride of them; buddy merge
// is dominated by the 11-step bit-serial remainder of stride by N; halve
// compares one pair of entries per cycle on the two read ports, and stops
// early at the first mismatch. Only one command is in flight; the output
// register lets the next command be accepted while the previous result waits.
// No clearing pass after reset: entry 0 reads as 1 until first written.
module hash_directory_table_engine_top #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned BLOCK_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hdt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [hdt_pkg::POS_W-1:0]    position_i,
  input  logic [hdt_pkg::VAL_W-1:0]    block_value_i,
  input  logic [hdt_pkg::STRIDE_W-1:0] stride_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [hdt_pkg::VAL_W-1:0]    read_value_o,
  output logic                         success_o,
  output logic [hdt_pkg::SIZE_W-1:0]   table_size_o,
  output logic [hdt_pkg::ERR_W-1:0]    error_o
);

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic                         accept;
  logic                         seq_idle;
  logic                         res_valid;
  logic                         res_take;
  hdt_pkg::res_t                res;
  hdt_pkg::res_t                out_q;
  logic                         out_valid_q;

  // RAM hookup
  logic                         we;
  logic [AW-1:0]                waddr, ra_addr, rb_addr;
  logic [BLOCK_BITS-1:0]        wdata, ra_data, rb_data;

  // remainder unit hookup
  logic                         rem_start, rem_done;
  logic [hdt_pkg::STRIDE_W-1:0] rem_dividend;
  logic [CW-1:0]                rem_divisor, rem;

  // check terms on the result port
  logic                         out_err, out_nonzero;

  assign in_stall_o = !seq_idle;
  assign accept     = in_valid_i && seq_idle;
  // result word moves into the output register when it is empty or draining
  assign res_take   = !out_valid_q || !out_stall_i;

  hdt_dir_mem #(
    .DEPTH(MAX_ENTRIES),
    .DW   (BLOCK_BITS)
  ) u_dir_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .ra_addr_i(ra_addr),
    .rb_addr_i(rb_addr),
    .ra_data_o(ra_data),
    .rb_data_o(rb_data)
  );

  hdt_rem #(
    .DIV_W(CW)
  ) u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(rem_dividend),
    .divisor_i (rem_divisor),
    .rem_o     (rem),
    .done_o    (rem_done)
  );

  hdt_seq #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (accept),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .block_value_i (block_value_i),
    .stride_i      (stride_i),
    .res_take_i    (res_take),
    .idle_o        (seq_idle),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .ra_addr_o     (ra_addr),
    .rb_addr_o     (rb_addr),
    .ra_data_i     (ra_data),
    .rb_data_i     (rb_data),
    .rem_start_o   (rem_start),
    .rem_dividend_o(rem_dividend),
    .rem_divisor_o (rem_divisor),
    .rem_i         (rem),
    .rem_done_i    (rem_done)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_q.read_value;
  assign success_o    = out_q.success;
  assign table_size_o = out_q.table_size;
  assign error_o      = out_q.error;

  assign out_err     = out_valid_o && (error_o != hdt_pkg::ERR_NONE);
  assign out_nonzero = out_valid_o && (read_value_o != '0);

`include "hash_directory_table_engine_top_assert.svh"

  // a flagged error never comes with success
  `HDTE_ASSERT_IMP(a_err_no_success, out_err, !success_o, "error word reports success")
  // only a successful lookup carries a nonzero value
  `HDTE_ASSERT_IMP(a_value_needs_success, out_nonzero, success_o, "value on failed word")
  // one command at a time: the port closes right after a word is taken
  `HDTE_ASSERT_NXT(a_busy_after_accept, accept, in_stall_o, "port open after accept")

endmodule
